// ----- hw/rtl/gaussian_splat_accumulator_defines.svh -----
// assertion macros for the splat accumulator
`ifndef GAUSSIAN_SPLAT_ACCUMULATOR_DEFINES_SVH
`define GAUSSIAN_SPLAT_ACCUMULATOR_DEFINES_SVH

// implication checked on every clock edge outside reset
`define GSA_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// implication with the consequent checked in the cycle after the antecedent
`define GSA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/gsa_pkg.sv -----
package gsa_pkg;

  localparam int unsigned MaxWidthDef    = 256;
  localparam int unsigned MaxHeightDef   = 256;
  localparam int unsigned FracBitsDef    = 8;
  localparam int unsigned CfgWidth       = 9;
  localparam int unsigned CfgIdxWidth    = 1;
  localparam int unsigned ColSumWidth    = 48;
  localparam int unsigned WgtSumWidth    = 32;
  localparam int unsigned WgtWidth       = 16;

  typedef enum logic [CfgIdxWidth-1:0] {
    CfgImageWidth  = 1'b0,
    CfgImageHeight = 1'b1
  } cfg_idx_e;

  typedef enum logic {
    OpSplat   = 1'b0,
    OpResolve = 1'b1
  } opcode_e;

  typedef enum logic [3:0] {
    StIdle,
    StClear,
    StPrep,
    StRowW,
    StColW,
    StMul,
    StRead,
    StWrite,
    StNext,
    StRdRes,
    StDiv,
    StDone
  } state_e;

  typedef struct packed {
    logic        opcode;
    logic [15:0] sample_x;
    logic [15:0] sample_y;
    logic [15:0] sample_red;
    logic [15:0] sample_green;
    logic [15:0] sample_blue;
    logic [15:0] pixel_index;
  } in_word_t;

  typedef struct packed {
    logic [15:0] out_red;
    logic [15:0] out_green;
    logic [15:0] out_blue;
    logic        covered;
    logic [15:0] out_index;
  } out_word_t;

  // exp(-a), a and result in q.30, taylor of a/16 then squared four times
  function automatic logic [63:0] exp_neg_q30(input logic [63:0] a);
    logic [63:0] s;
    logic [63:0] term;
    longint      sum;
    logic [63:0] v;
    logic [127:0] p;
    s = a >> 4;
    term = 64'd1 << 30;
    sum = longint'(64'd1 << 30);
    for (int k = 1; k <= 12; k++) begin
      p = 128'(term) * 128'(s);
      term = 64'(p >> 30) / 64'(k);
      if ((k % 2) == 1) sum = sum - longint'(term);
      else sum = sum + longint'(term);
    end
    v = (sum > 0) ? 64'(sum) : 64'd0;
    if (v > (64'd1 << 30)) v = 64'd1 << 30;
    for (int k = 0; k < 4; k++) begin
      p = 128'(v) * 128'(v);
      v = 64'(p >> 30);
    end
    return v;
  endfunction

  // 1-d truncated gaussian weight, |d| in units of 2^-frac px
  function automatic logic [WgtWidth-1:0] gauss_weight(input int unsigned i,
                                                       input int unsigned frac);
    logic [63:0] edge_v;
    logic [63:0] arg;
    logic [63:0] e;
    logic [63:0] g;
    edge_v = exp_neg_q30(64'd8 << 30);
    arg = (64'd2 * 64'(i) * 64'(i)) << (30 - 2 * frac);
    e = exp_neg_q30(arg);
    g = (e > edge_v) ? e - edge_v : 64'd0;
    g = (g + (64'd1 << 13)) >> 14;
    return (g > 64'd65535) ? 16'hFFFF : g[15:0];
  endfunction

endpackage

// ----- hw/rtl/gaussian_splat_accumulator.sv -----
// gaussian splat accumulator
// channels: command port start_i/busy_o with a packed input word; a result
// word appears on res_o for one cycle with res_valid_o high, it cannot be
// held off. configuration through cfg_we_i/cfg_idx_i/cfg_data_i, written
// while busy_o is low.
// a splat walks a 5x5 window around the sample one pixel at a time on a
// single multiplier and one read and one write port of the memory: one row
// weight step per row, and per pixel a column weight, a 2-d weight, three
// channel products, a read, a write and a step. at most a 4x4 window
// carries weight.
// a resolve reads one pixel and runs a 49-by-32 restoring divider, one
// quotient bit a cycle, for each channel in turn; an outside index or a
// zero weight skips division; the word appears in the cycle busy_o falls.
// reset starts a clearing pass that zeroes one pixel a cycle over all
// MAX_WIDTH*MAX_HEIGHT entries (65536 by default); busy_o is high
// throughout and no word is taken. configuration writes are taken at any
// time. the receiver cannot stall, so no result is ever held.
module gaussian_splat_accumulator
  import gsa_pkg::*;
#(
  parameter int unsigned MAX_WIDTH     = MaxWidthDef,
  parameter int unsigned MAX_HEIGHT    = MaxHeightDef,
  parameter int unsigned FRACTION_BITS = FracBitsDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  output logic                   busy_o,
  input  in_word_t               cmd_i,
  output logic                   res_valid_o,
  output out_word_t              res_o,
  input  logic                   cfg_we_i,
  input  logic [CfgIdxWidth-1:0] cfg_idx_i,
  input  logic [CfgWidth-1:0]    cfg_data_i
);

  localparam int unsigned Pixels  = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned AddrW   = $clog2(Pixels);
  localparam int unsigned TabLen  = (2 << FRACTION_BITS) + 1;
  localparam int unsigned TabW    = $clog2(TabLen);
  localparam int unsigned DimW    = $clog2(MAX_WIDTH > MAX_HEIGHT ? MAX_WIDTH : MAX_HEIGHT) + 1;
  localparam int unsigned PosW    = 16 - FRACTION_BITS + 3;
  localparam int unsigned MemW    = 3 * ColSumWidth + WgtSumWidth;
  localparam int unsigned DivW    = ColSumWidth + 1;
  localparam int unsigned DivCntW = $clog2(DivW + 1);

  // weight table as constant logic, built once
  function automatic logic [TabLen*WgtWidth-1:0] build_wtab();
    logic [TabLen*WgtWidth-1:0] t;
    t = '0;
    for (int unsigned k = 0; k < TabLen; k++) begin
      t[k*WgtWidth +: WgtWidth] = gauss_weight(k, FRACTION_BITS);
    end
    return t;
  endfunction

  localparam logic [TabLen*WgtWidth-1:0] WTab = build_wtab();

  // registers
  state_e state_q, state_d;
  logic [CfgWidth-1:0] width_q, height_q;
  in_word_t cmd_q, cmd_d;
  logic [AddrW:0] clr_q, clr_d;
  logic [2:0] row_q, row_d, col_q, col_d;
  logic [WgtWidth-1:0] wy_q, wy_d, wx_q, wx_d, wt_q, wt_d;
  logic [1:0] ch_q, ch_d;
  logic [ColSumWidth-1:0] prod_q [3];
  logic [ColSumWidth-1:0] prod_d [3];
  logic [MemW-1:0] rd_q;
  logic [DivW-1:0] rem_q, rem_d;
  logic [DivW-1:0] quo_q, quo_d;
  logic [DivCntW-1:0] dcnt_q, dcnt_d;
  logic [15:0] res_ch_q [3];
  logic [15:0] res_ch_d [3];
  logic res_cov_q, res_cov_d;
  logic res_valid_q, res_valid_d;

  // memory
  logic [MemW-1:0] mem_q [Pixels];
  logic            mem_we;
  logic [AddrW-1:0] mem_waddr, mem_raddr;
  logic [MemW-1:0] mem_wdata;

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_waddr] <= mem_wdata;
    rd_q <= mem_q[mem_raddr];
  end

  // effective dimensions
  logic [DimW-1:0] eff_w, eff_h;
  always_comb begin
    eff_w = (32'(width_q) > MAX_WIDTH) ? DimW'(MAX_WIDTH) : DimW'(width_q);
    eff_h = (32'(height_q) > MAX_HEIGHT) ? DimW'(MAX_HEIGHT) : DimW'(height_q);
  end

  // footprint coordinate and axis weight (shared for rows and columns)
  logic signed [PosW-1:0] pix_pos;
  logic [15:0]            ax_pos;
  logic [2:0]             ax_off;
  logic [DimW-1:0]        ax_lim;
  logic                   ax_in;
  logic signed [17:0]     ax_d;
  logic [17:0]            ax_ad;
  logic [WgtWidth-1:0]    ax_w;
  logic                   use_row;

  always_comb begin
    use_row = (state_q == StRowW);
    ax_pos  = use_row ? cmd_q.sample_y : cmd_q.sample_x;
    ax_off  = use_row ? row_q : col_q;
    ax_lim  = use_row ? eff_h : eff_w;
    pix_pos = PosW'($signed({1'b0, ax_pos >> FRACTION_BITS})) + PosW'($signed({1'b0, ax_off}))
              - PosW'(2);
    ax_in   = (pix_pos >= 0) && (32'(pix_pos) < 32'(ax_lim));
    ax_d    = $signed({2'b00, ax_pos}) - (18'(pix_pos) <<< FRACTION_BITS)
              - $signed(18'(1 << (FRACTION_BITS - 1)));
    ax_ad   = ax_d[17] ? 18'(-ax_d) : 18'(ax_d);
    ax_w    = (ax_ad >= 18'(2 << FRACTION_BITS) || !ax_in) ? '0
              : WTab[32'(ax_ad[TabW-1:0]) * WgtWidth +: WgtWidth];
  end

  // shared multiplier: 2-d weight first, then one channel a cycle
  logic [15:0] mul_a, mul_b;
  logic [31:0] mul_p;
  logic        wt_pass;
  always_comb begin
    wt_pass = (wt_q == '0) && (ch_q == 2'd0);
    mul_a = wx_q;
    mul_b = wy_q;
    if (state_q == StMul && !wt_pass) begin
      mul_a = wt_q;
      case (ch_q)
        2'd0:    mul_b = cmd_q.sample_red;
        2'd1:    mul_b = cmd_q.sample_green;
        default: mul_b = cmd_q.sample_blue;
      endcase
    end
    mul_p = 32'(mul_a) * 32'(mul_b);
  end

  // pixel address
  logic [31:0] pix_row, pix_col, pix_addr;
  always_comb begin
    pix_row  = 32'(cmd_q.sample_y >> FRACTION_BITS) + 32'(row_q) - 32'd2;
    pix_col  = 32'(cmd_q.sample_x >> FRACTION_BITS) + 32'(col_q) - 32'd2;
    pix_addr = pix_row * 32'(eff_w) + pix_col;
  end

  // saturating sums
  function automatic logic [ColSumWidth-1:0] add48(input logic [ColSumWidth-1:0] s,
                                                   input logic [ColSumWidth-1:0] v);
    logic [ColSumWidth:0] r;
    r = {1'b0, s} + {1'b0, v};
    return r[ColSumWidth] ? '1 : r[ColSumWidth-1:0];
  endfunction

  logic [WgtSumWidth:0] wsum_add;
  logic [WgtSumWidth-1:0] rd_w;
  logic [ColSumWidth-1:0] rd_ch;
  always_comb begin
    rd_w = rd_q[WgtSumWidth-1:0];
    case (ch_q)
      2'd0:    rd_ch = rd_q[MemW-1 -: ColSumWidth];
      2'd1:    rd_ch = rd_q[MemW-1-ColSumWidth -: ColSumWidth];
      default: rd_ch = rd_q[MemW-1-2*ColSumWidth -: ColSumWidth];
    endcase
    wsum_add = {1'b0, rd_w} + (WgtSumWidth+1)'(wt_q);
  end

  // divider step
  logic [DivW-1:0] rem_sh;
  logic [DivW:0]   rem_try;
  always_comb begin
    rem_sh  = {rem_q[DivW-2:0], quo_q[DivW-1]};
    rem_try = {1'b0, rem_sh} - (DivW+1)'(rd_w);
  end

  logic in_range;
  assign in_range = 32'(cmd_q.pixel_index) < 32'(eff_w) * 32'(eff_h);

  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    clr_d       = clr_q;
    row_d       = row_q;
    col_d       = col_q;
    wy_d        = wy_q;
    wx_d        = wx_q;
    wt_d        = wt_q;
    ch_d        = ch_q;
    prod_d      = prod_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    dcnt_d      = dcnt_q;
    res_ch_d    = res_ch_q;
    res_cov_d   = res_cov_q;
    res_valid_d = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = pix_addr[AddrW-1:0];
    mem_wdata   = {add48(rd_q[MemW-1 -: ColSumWidth], prod_q[0]),
                   add48(rd_q[MemW-1-ColSumWidth -: ColSumWidth], prod_q[1]),
                   add48(rd_q[MemW-1-2*ColSumWidth -: ColSumWidth], prod_q[2]),
                   wsum_add[WgtSumWidth] ? '1 : wsum_add[WgtSumWidth-1:0]};
    mem_raddr   = pix_addr[AddrW-1:0];
    case (state_q)
      StClear: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q[AddrW-1:0];
        mem_wdata = '0;
        clr_d     = clr_q + 1'b1;
        if (clr_q == (AddrW+1)'(Pixels - 1)) state_d = StIdle;
      end
      StIdle: begin
        if (start_i) begin
          cmd_d = cmd_i;
          row_d = '0;
          col_d = '0;
          state_d = (cmd_i.opcode == OpResolve) ? StRdRes : StRowW;
        end
      end
      StRowW: begin
        wy_d = ax_w;
        if (ax_w == '0) state_d = StNext;
        else state_d = StColW;
      end
      StColW: begin
        wx_d = ax_w;
        state_d = StMul;
        ch_d = 2'd0;
        wt_d = '0;
        if (ax_w == '0) state_d = StNext;
      end
      StMul: begin
        // first pass forms the 2-d weight, then one channel a cycle
        if (wt_pass) begin
          wt_d = 16'((mul_p + 32'h8000) >> 16);
          if (16'((mul_p + 32'h8000) >> 16) == '0) state_d = StNext;
        end else begin
          prod_d[ch_q] = ColSumWidth'(mul_p);
          ch_d = ch_q + 2'd1;
          if (ch_q == 2'd2) state_d = StRead;
        end
      end
      StRead: state_d = StWrite;
      StWrite: begin
        mem_we = 1'b1;
        state_d = StNext;
      end
      StNext: begin
        if (col_q == 3'd4 || wy_q == '0) begin
          col_d = '0;
          if (row_q == 3'd4) state_d = StIdle;
          else begin
            row_d = row_q + 3'd1;
            state_d = StRowW;
          end
        end else begin
          col_d = col_q + 3'd1;
          state_d = StColW;
        end
        wy_d = (col_q == 3'd4) ? '0 : wy_q;
        if (col_q != 3'd4 && wy_q != '0) wy_d = wy_q;
      end
      StRdRes: begin
        mem_raddr = cmd_q.pixel_index[AddrW-1:0];
        ch_d = 2'd0;
        state_d = StDiv;
        dcnt_d = '0;
        res_cov_d = 1'b0;
      end
      StDiv: begin
        // keep the pixel word on the read port for the whole division
        mem_raddr = cmd_q.pixel_index[AddrW-1:0];
        if (dcnt_q == '0) begin
          rem_d = '0;
          quo_d = {1'b0, rd_ch} + DivW'(rd_w >> 1);
          dcnt_d = dcnt_q + 1'b1;
          if (!in_range || rd_w == '0) begin
            res_ch_d[0] = '0;
            res_ch_d[1] = '0;
            res_ch_d[2] = '0;
            state_d = StDone;
          end
        end else if (dcnt_q <= DivCntW'(DivW)) begin
          if (!rem_try[DivW]) begin
            rem_d = rem_try[DivW-1:0];
            quo_d = {quo_q[DivW-2:0], 1'b1};
          end else begin
            rem_d = rem_sh;
            quo_d = {quo_q[DivW-2:0], 1'b0};
          end
          dcnt_d = dcnt_q + 1'b1;
        end else begin
          res_ch_d[ch_q] = (quo_q > DivW'(16'hFFFF)) ? 16'hFFFF : quo_q[15:0];
          dcnt_d = '0;
          ch_d = ch_q + 2'd1;
          if (ch_q == 2'd2) begin
            res_cov_d = 1'b1;
            state_d = StDone;
          end
        end
      end
      StDone: begin
        res_valid_d = 1'b1;
        state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  // state, clearing count, configuration and result strobe registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StClear;
      clr_q       <= '0;
      width_q     <= CfgWidth'(256);
      height_q    <= CfgWidth'(256);
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      res_valid_q <= res_valid_d;
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CfgImageWidth:  width_q  <= cfg_data_i;
          CfgImageHeight: height_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q     <= cmd_d;
    row_q     <= row_d;
    col_q     <= col_d;
    wy_q      <= wy_d;
    wx_q      <= wx_d;
    wt_q      <= wt_d;
    ch_q      <= ch_d;
    prod_q    <= prod_d;
    rem_q     <= rem_d;
    quo_q     <= quo_d;
    dcnt_q    <= dcnt_d;
    res_ch_q  <= res_ch_d;
    res_cov_q <= res_cov_d;
  end

  assign busy_o      = (state_q != StIdle);
  assign res_valid_o = res_valid_q;
  always_comb begin
    res_o.out_red   = res_ch_q[0];
    res_o.out_green = res_ch_q[1];
    res_o.out_blue  = res_ch_q[2];
    res_o.covered   = res_cov_q;
    res_o.out_index = cmd_q.pixel_index;
  end

`include "gaussian_splat_accumulator_defines.svh"

  `GSA_ASSERT_NEXT(a_done_gives_word, state_q == StDone, res_valid_o, "result word missing")
  `GSA_ASSERT_IMP(a_word_only_idle, res_valid_o, state_q == StIdle, "word outside idle")
  `GSA_ASSERT_IMP(a_no_write_in_resolve, state_q == StDiv, !mem_we, "write during resolve")

endmodule

// ----- verif/tb_top.sv -----
`default_nettype none

module tb_top
  import gsa_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned FRAC = FracBitsDef;
  localparam int unsigned LUT_LEN = (2 << FRAC) + 1;
  localparam int unsigned NPIX = MaxWidthDef * MaxHeightDef;
  localparam int unsigned STALL_LIMIT = 200000;
  localparam int unsigned SETTLE = 200;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic busy_o;
  in_word_t cmd_i = '0;
  logic res_valid_o;
  out_word_t res_o;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxWidth-1:0] cfg_idx_i = CfgImageWidth;
  logic [CfgWidth-1:0] cfg_data_i = '0;

  gaussian_splat_accumulator dut (
    .clk_i, .rst_ni, .start_i, .busy_o, .cmd_i, .res_valid_o, .res_o,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // predictor state
  logic [15:0] gauss_lut [LUT_LEN];
  logic [47:0] red_acc [NPIX];
  logic [47:0] green_acc [NPIX];
  logic [47:0] blue_acc [NPIX];
  logic [31:0] wgt_acc [NPIX];
  int unsigned img_w = 256;
  int unsigned img_h = 256;

  in_word_t pending_words[$];
  out_word_t resolve_due[$];
  int unsigned n_errors = 0;
  int unsigned n_splats = 0;
  int unsigned n_resolves = 0;
  int unsigned n_covered = 0;
  int unsigned n_phases = 0;

  // exp(-a) in q.30 by a series of a/16 squared four times
  function automatic longint unsigned lut_exp_q30(longint unsigned a);
    longint unsigned s, term, v;
    longint acc;
    s = a >> 4;
    term = 64'd1 << 30;
    acc = longint'(64'd1 << 30);
    for (int k = 1; k <= 12; k++) begin
      term = ((term * s) >> 30) / longint'(k);
      if (k % 2) acc -= longint'(term);
      else acc += longint'(term);
    end
    v = (acc > 0) ? longint'(acc) : 0;
    if (v > (64'd1 << 30)) v = 64'd1 << 30;
    for (int k = 0; k < 4; k++) v = (v * v) >> 30;
    return v;
  endfunction

  function automatic int unsigned eff_w();
    return (img_w > MaxWidthDef) ? MaxWidthDef : img_w;
  endfunction

  function automatic int unsigned eff_h();
    return (img_h > MaxHeightDef) ? MaxHeightDef : img_h;
  endfunction

  function automatic int unsigned axis_wt(int unsigned pos, int p);
    int d;
    d = int'(pos) - p * (1 << FRAC) - (1 << (FRAC - 1));
    if (d < 0) d = -d;
    if (d >= (2 << FRAC)) return 0;
    return gauss_lut[d];
  endfunction

  function automatic logic [47:0] sat48(logic [47:0] a, longint unsigned b);
    longint unsigned r;
    r = longint'(a) + b;
    return (r > 64'hFFFF_FFFF_FFFF) ? 48'hFFFF_FFFF_FFFF : r[47:0];
  endfunction

  function automatic void accumulate_splat(in_word_t w);
    int cx, cy, idx;
    int unsigned wx, wy, wt, ww, hh;
    longint unsigned ws;
    ww = eff_w();
    hh = eff_h();
    cx = int'(w.sample_x >> FRAC);
    cy = int'(w.sample_y >> FRAC);
    for (int row = cy - 2; row <= cy + 2; row++) begin
      if (row < 0 || row >= int'(hh)) continue;
      wy = axis_wt(32'(w.sample_y), row);
      if (wy == 0) continue;
      for (int col = cx - 2; col <= cx + 2; col++) begin
        if (col < 0 || col >= int'(ww)) continue;
        wx = axis_wt(32'(w.sample_x), col);
        wt = (wx * wy + (1 << 15)) >> 16;
        if (wt == 0) continue;
        idx = row * int'(ww) + col;
        red_acc[idx] = sat48(red_acc[idx], longint'(w.sample_red) * wt);
        green_acc[idx] = sat48(green_acc[idx], longint'(w.sample_green) * wt);
        blue_acc[idx] = sat48(blue_acc[idx], longint'(w.sample_blue) * wt);
        ws = longint'(wgt_acc[idx]) + wt;
        wgt_acc[idx] = (ws > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : ws[31:0];
      end
    end
  endfunction

  function automatic logic [15:0] norm_channel(logic [47:0] s, logic [31:0] ws);
    longint unsigned q;
    q = (longint'(s) + (ws >> 1)) / longint'(ws);
    return (q > 65535) ? 16'hFFFF : q[15:0];
  endfunction

  function automatic out_word_t resolve_pixel(logic [15:0] idx);
    out_word_t r;
    r = '0;
    r.out_index = idx;
    if (int'(idx) >= int'(eff_w() * eff_h()) || wgt_acc[idx] == 0) return r;
    r.out_red = norm_channel(red_acc[idx], wgt_acc[idx]);
    r.out_green = norm_channel(green_acc[idx], wgt_acc[idx]);
    r.out_blue = norm_channel(blue_acc[idx], wgt_acc[idx]);
    r.covered = 1'b1;
    return r;
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    n_errors++;
  endtask

  // driver: bursts with random gaps, word held until taken
  logic took_q = 1'b0;
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;

  always @(negedge clk_i) begin
    if (start_i && !took_q) begin
      // still waiting for the block
    end else if (gap_left > 0) begin
      gap_left--;
      start_i <= 1'b0;
    end else if (pending_words.size() > 0) begin
      cmd_i <= pending_words.pop_front();
      start_i <= 1'b1;
      if (burst_left == 0) burst_left = $urandom_range(1, 20);
      burst_left--;
      if (burst_left == 0) gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
    end else begin
      start_i <= 1'b0;
    end
  end

  // monitor, predictor and watchdog
  int unsigned quiet_cycles = 0;

  always @(posedge clk_i) begin
    out_word_t want;
    bit moved;
    moved = 1'b0;
    took_q <= start_i && !busy_o && rst_ni;
    if (rst_ni && cfg_we_i) begin
      if (cfg_idx_i == CfgImageWidth) img_w = 32'(cfg_data_i);
      else img_h = 32'(cfg_data_i);
    end
    if (rst_ni && start_i && !busy_o) begin
      moved = 1'b1;
      if (cmd_i.opcode == OpSplat) begin
        accumulate_splat(cmd_i);
        n_splats++;
      end else begin
        want = resolve_pixel(cmd_i.pixel_index);
        resolve_due = {resolve_due, want};
        n_resolves++;
        if (want.covered) n_covered++;
      end
    end
    if (rst_ni && res_valid_o) begin
      moved = 1'b1;
      if (resolve_due.size() == 0) begin
        report_mismatch("unexpected result, index", res_o.out_index, 0);
      end else begin
        want = resolve_due.pop_front();
        if (res_o.out_red !== want.out_red)
          report_mismatch("red", res_o.out_red, want.out_red);
        if (res_o.out_green !== want.out_green)
          report_mismatch("green", res_o.out_green, want.out_green);
        if (res_o.out_blue !== want.out_blue)
          report_mismatch("blue", res_o.out_blue, want.out_blue);
        if (res_o.covered !== want.covered)
          report_mismatch("covered", res_o.covered, want.covered);
        if (res_o.out_index !== want.out_index)
          report_mismatch("index", res_o.out_index, want.out_index);
      end
    end
    if (moved) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("watchdog expired with %0d words queued", pending_words.size());
      $display("FAILURE");
      $finish;
    end
  end

  // stimulus helpers
  int unsigned last_x = 0;
  int unsigned last_y = 0;

  function automatic logic [15:0] pick_colour();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom_range(0, 16'hFFFF));
    endcase
  endfunction

  function automatic in_word_t make_splat(int unsigned hot_x, int unsigned hot_y);
    in_word_t w;
    int unsigned ww, hh, span;
    w = '0;
    w.opcode = OpSplat;
    ww = eff_w();
    hh = eff_h();
    if ($urandom_range(0, 9) == 0) begin
      w.sample_x = 16'($urandom_range(0, 16'hFFFF));
      w.sample_y = 16'($urandom_range(0, 16'hFFFF));
    end else if (ww > 16) begin
      span = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 1535;
      w.sample_x = 16'(hot_x + $urandom_range(0, span));
      w.sample_y = 16'(hot_y + $urandom_range(0, span));
    end else begin
      w.sample_x = 16'($urandom_range(0, (ww + 2) * 256 - 1));
      w.sample_y = 16'($urandom_range(0, (hh + 2) * 256 - 1));
    end
    w.sample_red = pick_colour();
    w.sample_green = pick_colour();
    w.sample_blue = pick_colour();
    w.pixel_index = 16'($urandom_range(0, 16'hFFFF));
    last_x = 32'(w.sample_x);
    last_y = 32'(w.sample_y);
    return w;
  endfunction

  function automatic in_word_t make_resolve();
    in_word_t w;
    int unsigned ww, hh, col, row;
    w = '0;
    w.opcode = OpResolve;
    w.sample_x = 16'($urandom_range(0, 16'hFFFF));
    w.sample_y = 16'($urandom_range(0, 16'hFFFF));
    w.sample_red = 16'($urandom_range(0, 16'hFFFF));
    w.sample_green = 16'($urandom_range(0, 16'hFFFF));
    w.sample_blue = 16'($urandom_range(0, 16'hFFFF));
    ww = eff_w();
    hh = eff_h();
    case ($urandom_range(0, 9))
      0: w.pixel_index = 16'($urandom_range(0, 16'hFFFF));
      1: w.pixel_index = (ww * hh == 0) ? 16'd0 : 16'($urandom_range(0, ww * hh - 1));
      default: begin
        // near the last splat so that most reads are covered
        col = (last_x >> FRAC) + $urandom_range(0, 4);
        row = (last_y >> FRAC) + $urandom_range(0, 4);
        col = (col < 2) ? 0 : col - 2;
        row = (row < 2) ? 0 : row - 2;
        w.pixel_index = 16'(row * ww + col);
      end
    endcase
    return w;
  endfunction

  task automatic wait_idle();
    while (pending_words.size() > 0 || resolve_due.size() > 0 || start_i)
      @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CfgWidth-1:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic run_phase(int unsigned wv, int unsigned hv, int unsigned n_items);
    int unsigned hot_x, hot_y;
    wait_idle();
    write_reg(CfgImageWidth, CfgWidth'(wv));
    write_reg(CfgImageHeight, CfgWidth'(hv));
    @(posedge clk_i);
    n_phases++;
    hot_x = $urandom_range(0, 16'hFFFF);
    hot_y = $urandom_range(0, 16'hFFFF);
    if (eff_w() > 16) begin
      hot_x = $urandom_range(0, eff_w() * 256 - 1);
      hot_y = $urandom_range(0, eff_h() * 256 - 1);
    end
    for (int i = 0; i < n_items; i++) begin
      if ($urandom_range(0, 2) == 0) pending_words = {pending_words, make_resolve()};
      else pending_words = {pending_words, make_splat(hot_x, hot_y)};
    end
  endtask

  task automatic push_splat(int unsigned x, int unsigned y, int unsigned r,
                            int unsigned g, int unsigned b);
    in_word_t w;
    w = '0;
    w.opcode = OpSplat;
    w.sample_x = 16'(x);
    w.sample_y = 16'(y);
    w.sample_red = 16'(r);
    w.sample_green = 16'(g);
    w.sample_blue = 16'(b);
    pending_words = {pending_words, w};
  endtask

  task automatic push_resolve(int unsigned idx);
    in_word_t w;
    w = '0;
    w.opcode = OpResolve;
    w.pixel_index = 16'(idx);
    pending_words = {pending_words, w};
  endtask

  initial begin
    longint unsigned cut, e, g;
    cut = lut_exp_q30(64'd8 << 30);
    for (int i = 0; i < LUT_LEN; i++) begin
      e = lut_exp_q30((64'd2 * i * i) << (30 - 2 * FRAC));
      g = (e > cut) ? e - cut : 0;
      g = (g + (64'd1 << 13)) >> 14;
      gauss_lut[i] = (g > 65535) ? 16'hFFFF : g[15:0];
    end
    for (int i = 0; i < NPIX; i++) begin
      red_acc[i] = '0;
      green_acc[i] = '0;
      blue_acc[i] = '0;
      wgt_acc[i] = '0;
    end
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    while (busy_o !== 1'b0) @(posedge clk_i);

    // directed: corners, pixel centre, colour extremes and uncovered pixels
    push_resolve(0);
    push_splat(16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    push_splat(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h8000);
    push_splat(16'h0A80, 16'h0580, 16'h0100, 16'h0200, 16'h0300);
    push_splat(16'h0A00, 16'h0500, 16'h0000, 16'h0000, 16'h0000);
    push_splat(16'h0B7F, 16'h06FF, 16'hFFFF, 16'h0001, 16'h1234);
    push_resolve(0);
    push_resolve(1);
    push_resolve(257);
    push_resolve(16'hFFFF);
    push_resolve(16'hFEFF);
    push_resolve(5 * 256 + 10);
    push_resolve(5 * 256 + 8);
    push_resolve(6 * 256 + 11);
    push_resolve(3 * 256 + 10);
    push_resolve(1000);
    last_x = 16'h0A80;
    last_y = 16'h0580;
    for (int i = 0; i < 230; i++) begin
      if ($urandom_range(0, 2) == 0) pending_words = {pending_words, make_resolve()};
      else pending_words = {pending_words, make_splat(16'h0800, 16'h0400)};
    end

    // dimensions changed after splats keep the stores
    run_phase(7, 5, 200);
    run_phase(511, 300, 120);
    run_phase(0, 4, 40);
    run_phase(3, 0, 30);
    run_phase(1, 1, 80);
    run_phase(16, 12, 200);
    run_phase(256, 1, 120);
    run_phase(2, 256, 80);

    wait_idle();
    $display("covered %0d splats and %0d resolves (%0d of them covered) over %0d settings",
             n_splats, n_resolves, n_covered, n_phases + 1);
    if (n_errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches", n_errors);
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire
